FILE: rtl/core/hmnm_pkg.sv
// Package: shared widths, constants, job and result types for the normal map block.
package hmnm_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_HEIGHT = 4096;

  localparam int unsigned GREY_W  = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned RW_W    = 13;
  localparam int unsigned SCALE_W = 9;

  // Register indexes
  localparam logic [0:0] REG_ROW_WIDTH    = 1'd0;
  localparam logic [0:0] REG_HEIGHT_SCALE = 1'd1;

  // One normal to compute: neighbours plus position and tag
  typedef struct packed {
    logic [GREY_W-1:0] left;
    logic [GREY_W-1:0] centre;
    logic [GREY_W-1:0] next;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic              last;
  } hmnm_job_t;

  typedef struct packed {
    logic              last;
    logic [POS_W-1:0]  row;
    logic [POS_W-1:0]  col;
    logic [7:0]        nz;
    logic [7:0]        ny;
    logic [7:0]        nx;
  } hmnm_res_t;

endpackage

FILE: rtl/core/hmnm_ram.sv
// Generic single-port RAM with registered read.
module hmnm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Read old contents, then write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

FILE: rtl/core/hmnm_front.sv
// Front end: grey conversion, line buffer, neighbour selection, job emission.
module hmnm_front import hmnm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RW_W-1:0]   row_width,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        red,
  input  logic [7:0]        green,
  input  logic [7:0]        blue,
  input  logic              final_row,
  output logic              job_valid,
  input  logic              job_ready,
  output hmnm_job_t         job
);

  localparam int unsigned AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [CW-1:0] MAXW_C = CW'(MAX_WIDTH);
  localparam logic [HW:0]   MAXH_C = (HW+1)'(MAX_HEIGHT);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_PRIOR, S_OWN} state_t;

  state_t            state_r;
  logic [AW-1:0]     col_r;
  logic [HW-1:0]     row_r;
  logic [GREY_W-1:0] left_this_r, left_prior_r, grey_r;
  logic              fin_r;
  logic [9:0]        sum;
  logic [GREY_W-1:0] grey, old;
  logic [CW-1:0]     eff_w;
  logic              row_end;
  logic              retire;

  // Divide by three through a reciprocal: floor(s*683/2048) exact for s < 768
  assign sum  = 10'(red) + 10'(green) + 10'(blue);
  assign grey = GREY_W'((20'(sum) * 20'd683) >> 11);

  // Pixel leaves the front at the end of its own-job slot
  assign retire = (state_r == S_OWN) && (!fin_r || job_ready);

  // Read the old entry from S_READ on; write the new grey only as the pixel retires
  hmnm_ram #(.WIDTH(GREY_W), .DEPTH(1 << AW)) u_line (
    .clk   (clk),
    .we    (retire),
    .addr  (col_r),
    .wdata (grey_r),
    .rdata (old)
  );

  // Clamp width to 1..MAX_WIDTH
  always_comb begin
    eff_w = MAXW_C;
    if (row_width == '0) begin
      eff_w = CW'(1);
    end else if ({{(CW > RW_W ? CW-RW_W : 0){1'b0}}, row_width} < {{(RW_W > CW ? RW_W-CW : 0){1'b0}}, eff_w}) begin
      eff_w = CW'(row_width);
    end
    row_end = ({1'b0, col_r} + (AW+1)'(1)) >= (AW+1)'(eff_w);
  end

  assign in_ready = (state_r == S_IDLE);

  // Build jobs; prior slot only with a prior row, own slot only on the last row
  always_comb begin
    job_valid = ((state_r == S_PRIOR) && (row_r != '0)) || ((state_r == S_OWN) && fin_r);
    job.col   = POS_W'(col_r);
    job.next  = grey_r;
    if (state_r == S_PRIOR) begin
      job.left   = (col_r == '0) ? old : left_prior_r;
      job.centre = old;
      job.row    = POS_W'(row_r - HW'(1));
      job.last   = !fin_r;
    end else begin
      job.left   = (col_r == '0) ? grey_r : left_this_r;
      job.centre = grey_r;
      job.row    = POS_W'(row_r);
      job.last   = 1'b1;
    end
  end

  // Sequence one pixel: capture, read line, emit up to two jobs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      col_r        <= '0;
      row_r        <= '0;
      left_this_r  <= '0;
      left_prior_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            grey_r  <= grey;
            fin_r   <= final_row;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          state_r <= S_PRIOR;
        end
        S_PRIOR: begin
          if (row_r == '0 || job_ready) begin
            state_r <= S_OWN;
          end
        end
        S_OWN: begin
          if (retire) begin
            state_r      <= S_IDLE;
            left_prior_r <= old;
            left_this_r  <= grey_r;
            if (row_end) begin
              col_r <= '0;
              if (fin_r || ({1'b0, row_r} + (HW+1)'(1)) >= MAXH_C) begin
                row_r <= '0;
              end else begin
                row_r <= row_r + HW'(1);
              end
            end else begin
              col_r <= col_r + AW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/hmnm_queue.sv
// Two-entry job queue between front and back.
module hmnm_queue import hmnm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_valid,
  output logic      wr_ready,
  input  hmnm_job_t wr_data,
  output logic      rd_valid,
  input  logic      rd_ready,
  output hmnm_job_t rd_data
);

  hmnm_job_t mem_r [2];
  logic      wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        mem_r[wp_r] <= wr_data;
        wp_r        <= ~wp_r;
      end
      if (rd) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end

endmodule

FILE: rtl/core/hmnm_back.sv
// Back end: length by bit-serial square root, components by serial division.
module hmnm_back import hmnm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SCALE_W-1:0] height_scale,
  input  logic               job_valid,
  output logic               job_ready,
  input  hmnm_job_t          job,
  output logic               out_valid,
  input  logic               out_ready,
  output hmnm_res_t          res
);

  // Squares reach ~3*2^32: 34 bits, root 17 bits
  localparam int unsigned SQ_W = 36;
  localparam int unsigned RT_W = 18;
  localparam int unsigned NM_W = 26;  // 127*(2L) < 2^26

  typedef enum logic [2:0] {B_IDLE, B_SQX, B_SQY, B_SQZ, B_ROOT, B_DIV, B_OUT} state_t;

  state_t            state_r;
  hmnm_job_t         job_r;
  logic signed [17:0] x_r, y_r, z_r;
  logic [SQ_W-1:0]   acc_r, rem_r;
  logic [SQ_W-1:0]   res_r, bit_r;
  logic [1:0]        comp_r;
  logic [NM_W-1:0]   num_r, quo_r;
  logic [NM_W+RT_W-1:0] den_r;
  logic [4:0]        step_r;
  logic [7:0]        ch_r [3];
  logic signed [17:0] sq_in;
  logic [33:0]       sq;
  logic [8:0]        s_eff;
  logic signed [18:0] sum_c;
  logic [SQ_W-1:0]   trial;

  assign s_eff = (height_scale > 9'd256) ? 9'd256 : height_scale;

  // One 18x18 multiplier shared over the three squares
  always_comb begin
    unique case (state_r)
      B_SQX:   sq_in = x_r;
      B_SQY:   sq_in = y_r;
      default: sq_in = z_r;
    endcase
    sq = 34'(unsigned'(sq_in < 0 ? -sq_in : sq_in)) * 34'(unsigned'(sq_in < 0 ? -sq_in : sq_in));
    trial = res_r + bit_r;
    unique case (comp_r)
      2'd0:    sum_c = 19'(res_r) + 19'(x_r);
      2'd1:    sum_c = 19'(res_r) + 19'(y_r);
      default: sum_c = 19'(res_r) + 19'(z_r);
    endcase
  end

  assign job_ready = (state_r == B_IDLE);
  assign out_valid = (state_r == B_OUT);
  assign res.nx = ch_r[0];
  assign res.ny = ch_r[1];
  assign res.nz = ch_r[2];
  assign res.col  = job_r.col;
  assign res.row  = job_r.row;
  assign res.last = job_r.last;

  // Sequence the computation of one normal
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            x_r     <= 18'(($signed({10'd0, job.left}) - $signed({10'd0, job.centre})) <<< 8);
            y_r     <= 18'(($signed({10'd0, job.next}) - $signed({10'd0, job.centre})) <<< 8);
            z_r     <= $signed({1'b0, 17'(s_eff * 17'd255)});
            acc_r   <= '0;
            state_r <= B_SQX;
          end
        end
        B_SQX, B_SQY: begin
          acc_r   <= acc_r + SQ_W'(sq);
          state_r <= (state_r == B_SQX) ? B_SQY : B_SQZ;
        end
        B_SQZ: begin
          rem_r   <= acc_r + SQ_W'(sq);
          res_r   <= '0;
          bit_r   <= SQ_W'(1) << 34;
          state_r <= B_ROOT;
        end
        B_ROOT: begin
          // One result bit per cycle
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r == SQ_W'(1)) begin
            comp_r  <= 2'd0;
            step_r  <= '0;
            state_r <= B_DIV;
          end
        end
        B_DIV: begin
          // Restoring division, one quotient bit per cycle; step 0 loads
          if (step_r == 5'd0) begin
            if (res_r == '0) begin
              ch_r[comp_r] <= 8'd127;
              step_r       <= 5'd31;
            end else if (sum_c <= 0) begin
              ch_r[comp_r] <= 8'd0;
              step_r       <= 5'd31;
            end else begin
              num_r  <= NM_W'(unsigned'(sum_c)) * NM_W'(127);
              den_r  <= (NM_W+RT_W)'(res_r[RT_W-1:0]) << (NM_W-1);
              quo_r  <= '0;
              step_r <= 5'd1;
            end
          end else if (step_r <= 5'(NM_W)) begin
            if ((NM_W+RT_W)'(num_r) >= den_r) begin
              num_r <= num_r - NM_W'(den_r);
              quo_r <= (quo_r << 1) | NM_W'(1);
            end else begin
              quo_r <= quo_r << 1;
            end
            den_r  <= den_r >> 1;
            step_r <= step_r + 5'd1;
          end else begin
            if (step_r != 5'd31) begin
              ch_r[comp_r] <= (quo_r > NM_W'(254)) ? 8'd254 : quo_r[7:0];
            end
            step_r <= '0;
            if (comp_r == 2'd2) begin
              state_r <= B_OUT;
            end else begin
              comp_r <= comp_r + 2'd1;
            end
          end
        end
        B_OUT: begin
          if (out_ready) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/heightmap_normal_map_stream_top.sv
// Top level: stream in height pixels, stream out normals, APB registers.
//
// Input word: red, green, blue in in_tdata, final_row on in_tuser. A pixel is taken
// when in_tvalid and in_tready are high. Each pixel of row n>0 emits the normal of
// the pixel above it; last-row pixels (final_row=1) also emit their own normal,
// so a pixel causes zero, one or two output words, the last marked by out_tlast.
// Output word: normal_x, normal_y, normal_z, out_column, out_row in out_tdata.
// The front takes a pixel only when idle, then steps through capture, line-buffer
// read and two job slots. Each normal then passes the back end's squaring, root and
// division steps, which set the sustained rate; no new job enters until the result is taken.
// A two-entry queue decouples front and back; a stalled receiver holds the
// result in the back end's output register and, once the queue fills, backs
// pressure up to in_tready. Reset clears counters and restores registers to
// row_width 4096 and height_scale 256; line buffer contents are undefined until
// the first row is written. Registers: row_width at 0x0, height_scale at 0x4.
module heightmap_normal_map_stream_top import hmnm_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tuser,   // final_row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // normal_x, normal_y, normal_z, out_column, out_row
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [RW_W-1:0]    row_width_r;
  logic [SCALE_W-1:0] height_scale_r;
  logic      fj_valid, fj_ready, bj_valid, bj_ready;
  hmnm_job_t fj, bj;
  hmnm_res_t res;

  assign cfg_pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r    <= RW_W'(4096);
      height_scale_r <= SCALE_W'(256);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_ROW_WIDTH:    row_width_r    <= cfg_pwdata[RW_W-1:0];
        REG_HEIGHT_SCALE: height_scale_r <= cfg_pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (cfg_paddr[2])
      REG_ROW_WIDTH: cfg_prdata = 32'(row_width_r);
      default:       cfg_prdata = 32'(height_scale_r);
    endcase
  end

  hmnm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk, .rst_n,
    .row_width (row_width_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .final_row (in_tuser),
    .job_valid (fj_valid),
    .job_ready (fj_ready),
    .job       (fj)
  );

  hmnm_queue u_queue (
    .clk, .rst_n,
    .wr_valid (fj_valid), .wr_ready (fj_ready), .wr_data (fj),
    .rd_valid (bj_valid), .rd_ready (bj_ready), .rd_data (bj)
  );

  hmnm_back u_back (
    .clk, .rst_n,
    .height_scale (height_scale_r),
    .job_valid    (bj_valid),
    .job_ready    (bj_ready),
    .job          (bj),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .res          (res)
  );

  assign out_tdata = {res.row, res.col, res.nz, res.ny, res.nx};
  assign out_tlast = res.last;

endmodule

FILE: rtl/core/hmnm_checker.sv
// Port-level checker for the normal map block, bound to the top level.
module hmnm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic        cfg_pready
);

  // Components never exceed 254
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:0] != 8'hFF && out_tdata[15:8] != 8'hFF
                    && out_tdata[23:16] != 8'hFF))
    else $error("normal component out of range");

  // Stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed under stall");

  // Register port never waits
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

  // No output straight out of reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Input side ready straight out of reset
  a_ready: assert property (@(posedge clk) !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind heightmap_normal_map_stream_top hmnm_checker u_chk (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .cfg_pready
);
